### hw/rtl/ede_pkg.sv
// ----------------------------------------------------------------------------
// ede_pkg
// shared constants and types of the edit distance engine
// ----------------------------------------------------------------------------
package ede_pkg;

    localparam int MAX_LEN_DEF = 256;
    localparam int SYM_W       = 8;
    localparam int DIST_W      = 9;
    localparam int S_TDATA_W   = 8;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 16;
    localparam int M_TUSER_W   = 1;

    // s_tuser bit positions
    localparam int TUSER_MODE  = 0;
    localparam int TUSER_EMPTY = 1;

    // mode codes
    localparam logic MODE_REF   = 1'b0;
    localparam logic MODE_FIRST = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PASS,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic start;
        logic virt;
    } pass_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } pass_sts_t;

endpackage

### hw/rtl/ede_ram.sv
// ----------------------------------------------------------------------------
// ede_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module ede_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/ede_pass.sv
// ----------------------------------------------------------------------------
// ede_pass
// walks the cost row once per first-word character, one column per cycle:
// issues row and reference reads, then computes and writes back each column
// ----------------------------------------------------------------------------
module ede_pass #(
    parameter int MAX_LEN = ede_pkg::MAX_LEN_DEF,
    localparam int CW = $clog2(MAX_LEN + 1),
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  ede_pkg::pass_ctl_t       ctl,
    input  logic [ede_pkg::SYM_W-1:0] sym,
    input  logic [CW-1:0]            ref_len,
    input  logic [CW-1:0]            row_idx,
    output ede_pkg::pass_sts_t       sts,
    output logic [CW-1:0]            tail,
    output logic [AW-1:0]            rd_addr,
    input  logic [CW-1:0]            row_rdata,
    input  logic [ede_pkg::SYM_W-1:0] ref_rdata,
    output logic                     row_we,
    output logic [AW-1:0]            row_waddr,
    output logic [CW-1:0]            row_wdata
);

    logic                      issue_reg, issue_next;
    logic                      v_reg, v_next;
    logic [CW-1:0]             jiss_reg, jiss_next;
    logic [CW-1:0]             j_reg, j_next;
    logic [CW-1:0]             diag_reg, diag_next;
    logic [CW-1:0]             left_reg, left_next;
    logic                      virt_reg, virt_next;
    logic [ede_pkg::SYM_W-1:0] sym_reg, sym_next;
    logic [CW-1:0]             n_reg, n_next;

    logic [CW-1:0] up;
    logic [CW-1:0] mn;
    logic [CW-1:0] val;

    always_comb begin
        up = virt_reg ? j_reg : row_rdata;
        mn = (diag_reg < up) ? diag_reg : up;
        mn = (mn < left_reg) ? mn : left_reg;
        val = (ref_rdata == sym_reg) ? diag_reg : mn + CW'(1);
    end

    always_comb begin
        issue_next = issue_reg;
        v_next     = 1'b0;
        jiss_next  = jiss_reg;
        j_next     = j_reg;
        diag_next  = diag_reg;
        left_next  = left_reg;
        virt_next  = virt_reg;
        sym_next   = sym_reg;
        n_next     = n_reg;
        if (issue_reg) begin
            v_next     = 1'b1;
            j_next     = jiss_reg;
            jiss_next  = jiss_reg + CW'(1);
            issue_next = (jiss_reg != n_reg);
        end
        if (v_reg) begin
            diag_next = up;
            left_next = val;
        end
        if (ctl.start) begin
            issue_next = 1'b1;
            jiss_next  = CW'(1);
            diag_next  = row_idx;
            left_next  = row_idx + CW'(1);
            virt_next  = ctl.virt;
            sym_next   = sym;
            n_next     = ref_len;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_reg <= 1'b0;
            v_reg     <= 1'b0;
        end else begin
            issue_reg <= issue_next;
            v_reg     <= v_next;
        end
        jiss_reg <= jiss_next;
        j_reg    <= j_next;
        diag_reg <= diag_next;
        left_reg <= left_next;
        virt_reg <= virt_next;
        sym_reg  <= sym_next;
        n_reg    <= n_next;
    end

    assign rd_addr   = AW'(jiss_reg - CW'(1));
    assign row_we    = v_reg;
    assign row_waddr = AW'(j_reg - CW'(1));
    assign row_wdata = val;
    assign tail      = val;
    assign sts.busy  = issue_reg | v_reg;
    assign sts.done  = v_reg && (j_reg == n_reg);

endmodule

### hw/rtl/edit_distance_engine_unit.sv
// ----------------------------------------------------------------------------
// edit_distance_engine_unit
// levenshtein distance between a stored reference word and streamed words
// ----------------------------------------------------------------------------
// reference item (mode 0): stored in the reference memory unless empty or full
// first-word character: walks the cost row memory over the n = reference length
//   columns, one column per cycle; no walk for n = 0
// empty or truncated first-word item: no walk over the cost row
// a first-word item with last goes on to load the result, held while one waits
// reset clears control state only, the memories are not cleared
// ----------------------------------------------------------------------------
module edit_distance_engine_unit #(
    parameter int MAX_LEN = ede_pkg::MAX_LEN_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ede_pkg::S_TDATA_W-1:0] s_tdata,   // symbol
    input  logic [ede_pkg::S_TUSER_W-1:0] s_tuser,   // mode, empty_req
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ede_pkg::M_TDATA_W-1:0] m_tdata,   // distance, zero pad
    output logic [ede_pkg::M_TUSER_W-1:0] m_tuser    // overflow
);

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    ede_pkg::state_t state_reg, state_next;

    logic [CW-1:0] len_reg, len_next;
    logic [CW-1:0] fwc_reg, fwc_next;
    logic          ovf_reg, ovf_next;
    logic          loading_reg, loading_next;
    logic [CW-1:0] tail_reg, tail_next;
    logic [CW-1:0] res_reg, res_next;
    logic          last_reg, last_next;

    logic                          mtv_reg, mtv_next;
    logic [ede_pkg::DIST_W-1:0]    mdist_reg, mdist_next;
    logic                          movf_reg, movf_next;

    logic                      accept;
    logic                      mode;
    logic                      empty;
    logic [ede_pkg::SYM_W-1:0] sym;
    logic [CW-1:0]             len_eff;
    logic [CW-1:0]             fwc_eff;

    logic                      ref_we;
    ede_pkg::pass_ctl_t        pctl;
    ede_pkg::pass_sts_t        psts;
    logic [CW-1:0]             ptail;
    logic [AW-1:0]             rd_addr;
    logic [CW-1:0]             row_rdata;
    logic [ede_pkg::SYM_W-1:0] ref_rdata;
    logic                      row_we;
    logic [AW-1:0]             row_waddr;
    logic [CW-1:0]             row_wdata;

    assign s_tready = (state_reg == ede_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign mode     = s_tuser[ede_pkg::TUSER_MODE];
    assign empty    = s_tuser[ede_pkg::TUSER_EMPTY];
    assign sym      = s_tdata[ede_pkg::SYM_W-1:0];
    assign len_eff  = loading_reg ? len_reg : '0;
    assign fwc_eff  = loading_reg ? '0 : fwc_reg;

    always_comb begin
        state_next   = state_reg;
        len_next     = len_reg;
        fwc_next     = fwc_reg;
        ovf_next     = ovf_reg;
        loading_next = loading_reg;
        tail_next    = tail_reg;
        res_next     = res_reg;
        last_next    = last_reg;
        mtv_next     = mtv_reg && !m_tready;
        mdist_next   = mdist_reg;
        movf_next    = movf_reg;
        ref_we       = 1'b0;
        pctl.start   = 1'b0;
        pctl.virt    = (fwc_eff == '0);

        unique case (state_reg)
            ede_pkg::ST_IDLE: begin
                if (accept && mode == ede_pkg::MODE_REF) begin
                    // a load that starts fresh clears length and flag
                    len_next     = len_eff;
                    ovf_next     = loading_reg ? ovf_reg : 1'b0;
                    fwc_next     = '0;
                    loading_next = !s_tlast;
                    if (!empty) begin
                        if (len_eff < CW'(MAX_LEN)) begin
                            ref_we   = 1'b1;
                            len_next = len_eff + CW'(1);
                        end else begin
                            ovf_next = 1'b1;
                        end
                    end
                end else if (accept) begin
                    loading_next = 1'b0;
                    last_next    = s_tlast;
                    if (!empty && fwc_eff < CW'(MAX_LEN)) begin
                        fwc_next = s_tlast ? '0 : fwc_eff + CW'(1);
                        if (len_reg == '0) begin
                            tail_next = fwc_eff + CW'(1);
                            res_next  = fwc_eff + CW'(1);
                            if (s_tlast) begin
                                state_next = ede_pkg::ST_EMIT;
                            end
                        end else begin
                            pctl.start = 1'b1;
                            state_next = ede_pkg::ST_PASS;
                        end
                    end else begin
                        if (!empty) begin
                            ovf_next = 1'b1;
                        end
                        fwc_next = s_tlast ? '0 : fwc_eff;
                        res_next = (fwc_eff == '0) ? len_reg : tail_reg;
                        if (s_tlast) begin
                            state_next = ede_pkg::ST_EMIT;
                        end
                    end
                end
            end
            ede_pkg::ST_PASS: begin
                if (psts.done) begin
                    tail_next  = ptail;
                    res_next   = ptail;
                    state_next = last_reg ? ede_pkg::ST_EMIT : ede_pkg::ST_IDLE;
                end
            end
            ede_pkg::ST_EMIT: begin
                if (!mtv_reg || m_tready) begin
                    mtv_next   = 1'b1;
                    mdist_next = ede_pkg::DIST_W'(res_reg);
                    movf_next  = ovf_reg;
                    state_next = ede_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ede_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ede_pkg::ST_IDLE;
            len_reg     <= '0;
            fwc_reg     <= '0;
            ovf_reg     <= 1'b0;
            loading_reg <= 1'b0;
            mtv_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            fwc_reg     <= fwc_next;
            ovf_reg     <= ovf_next;
            loading_reg <= loading_next;
            mtv_reg     <= mtv_next;
        end
        tail_reg  <= tail_next;
        res_reg   <= res_next;
        last_reg  <= last_next;
        mdist_reg <= mdist_next;
        movf_reg  <= movf_next;
    end

    ede_ram #(
        .WIDTH (ede_pkg::SYM_W),
        .DEPTH (MAX_LEN)
    ) u_ref_ram (
        .aclk  (aclk),
        .we    (ref_we),
        .waddr (AW'(len_eff)),
        .wdata (sym),
        .raddr (rd_addr),
        .rdata (ref_rdata)
    );

    ede_ram #(
        .WIDTH (CW),
        .DEPTH (MAX_LEN)
    ) u_row_ram (
        .aclk  (aclk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .raddr (rd_addr),
        .rdata (row_rdata)
    );

    ede_pass #(
        .MAX_LEN (MAX_LEN)
    ) u_pass (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (pctl),
        .sym       (sym),
        .ref_len   (len_reg),
        .row_idx   (fwc_eff),
        .sts       (psts),
        .tail      (ptail),
        .rd_addr   (rd_addr),
        .row_rdata (row_rdata),
        .ref_rdata (ref_rdata),
        .row_we    (row_we),
        .row_waddr (row_waddr),
        .row_wdata (row_wdata)
    );

    assign m_tvalid = mtv_reg;
    assign m_tdata  = ede_pkg::M_TDATA_W'(mdist_reg);
    assign m_tuser  = movf_reg;

    // row walk only runs while the control waits for it
    a_pass_in_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        psts.busy |-> state_reg == ede_pkg::ST_PASS)
        else $error("row walk active outside pass state");

    a_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= CW'(MAX_LEN))
        else $error("reference length beyond limit");

    a_fwc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fwc_reg <= CW'(MAX_LEN))
        else $error("first word count beyond limit");

    a_loading_fwc: assert property (@(posedge aclk) disable iff (!aresetn)
        loading_reg |-> fwc_reg == '0)
        else $error("first word count live during reference load");

    a_emit_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(mtv_reg) |-> $past(state_reg == ede_pkg::ST_EMIT))
        else $error("result transfer raised outside emit state");

endmodule
